// ===== rtl/weighted_round_robin_task_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// scheduler assertion macros
// clocked concurrent assertions with the synchronous reset as disable
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

// assertion with a fixed message
`define WRRTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wrrts assertion failed");

// assertion with a caller message
`define WRRTS_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

// ===== rtl/wrrts_pkg.sv =====
// ----------------------------------------------------------------------------
// scheduler package
// widths, codes, task entry layout and controller/datapath interface types
// ----------------------------------------------------------------------------
package wrrts_pkg;

   localparam int NUM_TASKS_DEFAULT = 8;
   localparam int CMD_W             = 3;
   localparam int SLOT_W            = 3;
   localparam int WEIGHT_W          = 8;
   localparam int COUNT_W           = 16;
   localparam int CSR_INDEX_W       = 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MIN_RESET = 8'd1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX_RESET = 8'd16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_MIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_MAX = 2'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_REGISTER   = 3'd1,
      CMD_UNREGISTER = 3'd2,
      CMD_SET_WEIGHT = 3'd3,
      CMD_STOP       = 3'd4,
      CMD_BLOCK      = 3'd5,
      CMD_WAKE       = 3'd6,
      CMD_STATS      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      TS_UNUSED  = 2'd0,
      TS_READY   = 2'd1,
      TS_WAITING = 2'd2
   } task_state_type;

   // one task ram word
   typedef struct packed {
      logic [COUNT_W-1:0]  busy;
      logic                stop;
      logic [WEIGHT_W-1:0] budget;
      logic [WEIGHT_W-1:0] weight;
   } task_entry_type;

   // datapath operations issued by the controller, one per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_TICK_BEGIN,
      OP_TICK_KEEP,
      OP_TICK_RELOAD,
      OP_SCAN,
      OP_SCAN_HIT,
      OP_SCAN_IDLE,
      OP_REG_BEGIN,
      OP_REG_TAKE,
      OP_REG_NEXT,
      OP_REJECT,
      OP_RMW_READ,
      OP_UNREG,
      OP_SETW,
      OP_STOP,
      OP_BLOCK,
      OP_WAKE,
      OP_STATS
   } dp_op_type;

   // datapath status seen by the controller
   typedef struct packed {
      cmd_type cmd;
      logic    in_range;
      logic    used;
      logic    cur_ready;
      logic    next_ready;
      logic    scan_last;
      logic    budget_gt1;
      logic    reg_free;
      logic    reg_last;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TICK_CUR,
      ST_SCAN,
      ST_SCAN_HIT,
      ST_REG,
      ST_RMW
   } ctl_state_type;

endpackage

// ===== rtl/wrrts_ram.sv =====
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module wrrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wrrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// scheduler controller
// sequences ticks, slot scans, registration, read-modify-write and block/wake commands
// ----------------------------------------------------------------------------
module wrrts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  wrrts_pkg::dp_status_type status,
   output wrrts_pkg::dp_op_type    op
);

   wrrts_pkg::ctl_state_type state_ff;
   wrrts_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrrts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op       = wrrts_pkg::OP_NONE;
      case (state_ff)
         wrrts_pkg::ST_IDLE: begin
            if (start) begin
               op       = wrrts_pkg::OP_LATCH;
               state_in = wrrts_pkg::ST_DECODE;
            end
         end
         wrrts_pkg::ST_DECODE: begin
            case (status.cmd)
               wrrts_pkg::CMD_TICK: begin
                  op       = wrrts_pkg::OP_TICK_BEGIN;
                  state_in = status.cur_ready ? wrrts_pkg::ST_TICK_CUR : wrrts_pkg::ST_SCAN;
               end
               wrrts_pkg::CMD_REGISTER: begin
                  op       = wrrts_pkg::OP_REG_BEGIN;
                  state_in = wrrts_pkg::ST_REG;
               end
               wrrts_pkg::CMD_UNREGISTER, wrrts_pkg::CMD_SET_WEIGHT,
               wrrts_pkg::CMD_STOP: begin
                  if (status.used) begin
                     op       = wrrts_pkg::OP_RMW_READ;
                     state_in = wrrts_pkg::ST_RMW;
                  end else begin
                     op       = wrrts_pkg::OP_REJECT;
                     state_in = wrrts_pkg::ST_IDLE;
                  end
               end
               wrrts_pkg::CMD_BLOCK: begin
                  op       = status.used ? wrrts_pkg::OP_BLOCK : wrrts_pkg::OP_REJECT;
                  state_in = wrrts_pkg::ST_IDLE;
               end
               wrrts_pkg::CMD_WAKE: begin
                  op       = status.used ? wrrts_pkg::OP_WAKE : wrrts_pkg::OP_REJECT;
                  state_in = wrrts_pkg::ST_IDLE;
               end
               wrrts_pkg::CMD_STATS: begin
                  if (status.in_range) begin
                     op       = wrrts_pkg::OP_RMW_READ;
                     state_in = wrrts_pkg::ST_RMW;
                  end else begin
                     op       = wrrts_pkg::OP_REJECT;
                     state_in = wrrts_pkg::ST_IDLE;
                  end
               end
               default: begin
                  op       = wrrts_pkg::OP_REJECT;
                  state_in = wrrts_pkg::ST_IDLE;
               end
            endcase
         end
         wrrts_pkg::ST_TICK_CUR: begin
            if (status.budget_gt1) begin
               op       = wrrts_pkg::OP_TICK_KEEP;
               state_in = wrrts_pkg::ST_IDLE;
            end else begin
               op       = wrrts_pkg::OP_TICK_RELOAD;
               state_in = wrrts_pkg::ST_SCAN;
            end
         end
         wrrts_pkg::ST_SCAN: begin
            if (status.next_ready) begin
               op       = wrrts_pkg::OP_SCAN;
               state_in = wrrts_pkg::ST_SCAN_HIT;
            end else if (status.scan_last) begin
               op       = wrrts_pkg::OP_SCAN_IDLE;
               state_in = wrrts_pkg::ST_IDLE;
            end else begin
               op       = wrrts_pkg::OP_SCAN;
            end
         end
         wrrts_pkg::ST_SCAN_HIT: begin
            op       = wrrts_pkg::OP_SCAN_HIT;
            state_in = wrrts_pkg::ST_IDLE;
         end
         wrrts_pkg::ST_REG: begin
            if (status.reg_free) begin
               op       = wrrts_pkg::OP_REG_TAKE;
               state_in = wrrts_pkg::ST_IDLE;
            end else if (status.reg_last) begin
               op       = wrrts_pkg::OP_REJECT;
               state_in = wrrts_pkg::ST_IDLE;
            end else begin
               op       = wrrts_pkg::OP_REG_NEXT;
            end
         end
         wrrts_pkg::ST_RMW: begin
            state_in = wrrts_pkg::ST_IDLE;
            case (status.cmd)
               wrrts_pkg::CMD_UNREGISTER: op = wrrts_pkg::OP_UNREG;
               wrrts_pkg::CMD_SET_WEIGHT: op = wrrts_pkg::OP_SETW;
               wrrts_pkg::CMD_STOP:       op = wrrts_pkg::OP_STOP;
               wrrts_pkg::CMD_STATS:      op = wrrts_pkg::OP_STATS;
               default:                   op = wrrts_pkg::OP_REJECT;
            endcase
         end
         default: begin
            state_in = wrrts_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != wrrts_pkg::ST_IDLE);

endmodule

// ===== rtl/wrrts_dp.sv =====
// ----------------------------------------------------------------------------
// scheduler datapath
// task status flags, task ram, counters, probe pointer and result registers
// ----------------------------------------------------------------------------
module wrrts_dp #(
   parameter int NUM_TASKS = wrrts_pkg::NUM_TASKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wrrts_pkg::dp_op_type                 op,
   output wrrts_pkg::dp_status_type             status,
   input  logic [wrrts_pkg::CMD_W-1:0]          req_cmd,
   input  logic [wrrts_pkg::SLOT_W-1:0]         req_slot,
   input  logic [wrrts_pkg::WEIGHT_W-1:0]       req_weight,
   input  logic                                 csr_we,
   input  logic [wrrts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wrrts_pkg::WEIGHT_W-1:0]       csr_data,
   output logic                                 rsp_valid,
   output logic                                 rsp_ok,
   output logic [wrrts_pkg::SLOT_W-1:0]         rsp_slot_id,
   output logic [wrrts_pkg::SLOT_W-1:0]         rsp_current_task,
   output logic                                 rsp_went_idle,
   output logic [wrrts_pkg::COUNT_W-1:0]        rsp_busy_ticks,
   output logic [wrrts_pkg::COUNT_W-1:0]        rsp_idle_ticks,
   output logic [wrrts_pkg::COUNT_W-1:0]        rsp_total_ticks,
   output logic                                 rsp_stop_flag
);

   localparam int IDX_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int LEFT_W  = $clog2(NUM_TASKS + 1);
   localparam int ENTRY_W = $bits(wrrts_pkg::task_entry_type);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_TASKS - 1);
   localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(NUM_TASKS);

   // item and configuration
   wrrts_pkg::cmd_type                  item_cmd_ff, item_cmd_in;
   logic [wrrts_pkg::SLOT_W-1:0]        item_slot_ff, item_slot_in;
   logic [wrrts_pkg::WEIGHT_W-1:0]      item_weight_ff, item_weight_in;
   logic [wrrts_pkg::WEIGHT_W-1:0]      wmin_ff, wmin_in;
   logic [wrrts_pkg::WEIGHT_W-1:0]      wmax_ff, wmax_in;

   // task table flags and counters
   wrrts_pkg::task_state_type           status_ff [NUM_TASKS];
   wrrts_pkg::task_state_type           status_in [NUM_TASKS];
   logic [NUM_TASKS-1:0]                written_ff, written_in;
   logic [IDX_W-1:0]                    running_ff, running_in;
   logic [IDX_W-1:0]                    probe_ff, probe_in;
   logic [LEFT_W-1:0]                   left_ff, left_in;
   logic [wrrts_pkg::COUNT_W-1:0]       idle_count_ff, idle_count_in;
   logic [wrrts_pkg::COUNT_W-1:0]       tick_total_ff, tick_total_in;
   logic                                rd_written_ff, rd_written_in;

   // result registers
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_ok_ff, rsp_ok_in;
   logic [wrrts_pkg::SLOT_W-1:0]        rsp_slot_id_ff, rsp_slot_id_in;
   logic [wrrts_pkg::SLOT_W-1:0]        rsp_current_task_ff, rsp_current_task_in;
   logic                                rsp_went_idle_ff, rsp_went_idle_in;
   logic [wrrts_pkg::COUNT_W-1:0]       rsp_busy_ticks_ff, rsp_busy_ticks_in;
   logic [wrrts_pkg::COUNT_W-1:0]       rsp_idle_ticks_ff, rsp_idle_ticks_in;
   logic [wrrts_pkg::COUNT_W-1:0]       rsp_total_ticks_ff, rsp_total_ticks_in;
   logic                                rsp_stop_ff, rsp_stop_in;

   // ram port signals
   logic                                ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]                    ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]                  ram_rd_data;
   wrrts_pkg::task_entry_type           wr_entry, rd_entry;

   // finish controls
   logic                                fin, fin_ok, fin_idle, fin_stats;
   logic [wrrts_pkg::SLOT_W-1:0]        fin_sid;

   logic [IDX_W-1:0]                    slot_idx, next_probe;
   logic [wrrts_pkg::WEIGHT_W-1:0]      wclamp;
   logic                                in_range, used;

   wrrts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TASKS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // never registered slots read as zero
   assign rd_entry = rd_written_ff ? wrrts_pkg::task_entry_type'(ram_rd_data) : '0;

   assign slot_idx   = IDX_W'(item_slot_ff);
   assign in_range   = (32'(item_slot_ff) < 32'(NUM_TASKS));
   assign used       = in_range && (status_ff[slot_idx] != wrrts_pkg::TS_UNUSED);
   assign next_probe = (probe_ff == LAST_IDX) ? '0 : probe_ff + IDX_W'(1);

   // lower clamp is tested first
   assign wclamp = (item_weight_ff < wmin_ff) ? wmin_ff :
                   (item_weight_ff > wmax_ff) ? wmax_ff : item_weight_ff;

   always_comb begin
      status.cmd        = item_cmd_ff;
      status.in_range   = in_range;
      status.used       = used;
      status.cur_ready  = (status_ff[running_ff] == wrrts_pkg::TS_READY);
      status.next_ready = (status_ff[next_probe] == wrrts_pkg::TS_READY);
      status.scan_last  = (left_ff == LEFT_W'(1));
      status.budget_gt1 = (rd_entry.budget > 8'd1);
      status.reg_free   = (status_ff[probe_ff] == wrrts_pkg::TS_UNUSED);
      status.reg_last   = (probe_ff == LAST_IDX);
   end

   always_comb begin
      item_cmd_in    = item_cmd_ff;
      item_slot_in   = item_slot_ff;
      item_weight_in = item_weight_ff;
      wmin_in        = wmin_ff;
      wmax_in        = wmax_ff;
      status_in      = status_ff;
      written_in     = written_ff;
      running_in     = running_ff;
      probe_in       = probe_ff;
      left_in        = left_ff;
      idle_count_in  = idle_count_ff;
      tick_total_in  = tick_total_ff;
      rd_written_in  = rd_written_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_wr_addr    = probe_ff;
      ram_rd_addr    = probe_ff;
      wr_entry       = rd_entry;
      fin            = 1'b0;
      fin_ok         = 1'b1;
      fin_idle       = 1'b0;
      fin_stats      = 1'b0;
      fin_sid        = '0;

      if (csr_we) begin
         if (csr_index == wrrts_pkg::CSR_WEIGHT_MIN) begin
            wmin_in = csr_data;
         end else if (csr_index == wrrts_pkg::CSR_WEIGHT_MAX) begin
            wmax_in = csr_data;
         end
      end

      case (op)
         wrrts_pkg::OP_LATCH: begin
            item_cmd_in    = wrrts_pkg::cmd_type'(req_cmd);
            item_slot_in   = req_slot;
            item_weight_in = req_weight;
         end
         wrrts_pkg::OP_TICK_BEGIN: begin
            tick_total_in = tick_total_ff + 16'd1;
            probe_in      = running_ff;
            left_in       = LEFT_INIT;
            ram_rd_en     = 1'b1;
            ram_rd_addr   = running_ff;
         end
         wrrts_pkg::OP_TICK_KEEP: begin
            ram_wr_en       = 1'b1;
            wr_entry.budget = rd_entry.budget - 8'd1;
            wr_entry.busy   = rd_entry.busy + 16'd1;
            fin             = 1'b1;
         end
         wrrts_pkg::OP_TICK_RELOAD: begin
            ram_wr_en       = 1'b1;
            wr_entry.budget = rd_entry.weight;
         end
         wrrts_pkg::OP_SCAN: begin
            probe_in    = next_probe;
            left_in     = left_ff - LEFT_W'(1);
            ram_rd_en   = 1'b1;
            ram_rd_addr = next_probe;
         end
         wrrts_pkg::OP_SCAN_HIT: begin
            ram_wr_en = 1'b1;
            if (rd_entry.budget == 8'd0) begin
               wr_entry.budget = rd_entry.weight;
            end
            wr_entry.busy = rd_entry.busy + 16'd1;
            running_in    = probe_ff;
            fin           = 1'b1;
         end
         wrrts_pkg::OP_SCAN_IDLE: begin
            idle_count_in = idle_count_ff + 16'd1;
            fin           = 1'b1;
            fin_idle      = 1'b1;
         end
         wrrts_pkg::OP_REG_BEGIN: begin
            probe_in = '0;
         end
         wrrts_pkg::OP_REG_TAKE: begin
            ram_wr_en            = 1'b1;
            wr_entry.busy        = '0;
            wr_entry.stop        = 1'b0;
            wr_entry.budget      = wclamp;
            wr_entry.weight      = wclamp;
            status_in[probe_ff]  = wrrts_pkg::TS_READY;
            written_in[probe_ff] = 1'b1;
            fin                  = 1'b1;
            fin_sid              = wrrts_pkg::SLOT_W'(probe_ff);
         end
         wrrts_pkg::OP_REG_NEXT: begin
            probe_in = probe_ff + IDX_W'(1);
         end
         wrrts_pkg::OP_REJECT: begin
            fin    = 1'b1;
            fin_ok = 1'b0;
         end
         wrrts_pkg::OP_RMW_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = slot_idx;
         end
         wrrts_pkg::OP_UNREG: begin
            ram_wr_en           = 1'b1;
            ram_wr_addr         = slot_idx;
            wr_entry.stop       = 1'b0;
            wr_entry.budget     = '0;
            wr_entry.weight     = '0;
            status_in[slot_idx] = wrrts_pkg::TS_UNUSED;
            fin                 = 1'b1;
         end
         wrrts_pkg::OP_SETW: begin
            ram_wr_en       = 1'b1;
            ram_wr_addr     = slot_idx;
            wr_entry.weight = wclamp;
            if ((rd_entry.budget == 8'd0) || (rd_entry.budget > wclamp)) begin
               wr_entry.budget = wclamp;
            end
            fin = 1'b1;
         end
         wrrts_pkg::OP_STOP: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = slot_idx;
            wr_entry.stop = 1'b1;
            if (status_ff[slot_idx] == wrrts_pkg::TS_WAITING) begin
               status_in[slot_idx] = wrrts_pkg::TS_READY;
            end
            fin = 1'b1;
         end
         wrrts_pkg::OP_BLOCK: begin
            status_in[slot_idx] = wrrts_pkg::TS_WAITING;
            fin                 = 1'b1;
         end
         wrrts_pkg::OP_WAKE: begin
            if (status_ff[slot_idx] == wrrts_pkg::TS_WAITING) begin
               status_in[slot_idx] = wrrts_pkg::TS_READY;
            end
            fin = 1'b1;
         end
         wrrts_pkg::OP_STATS: begin
            fin       = 1'b1;
            fin_stats = 1'b1;
         end
         default: begin
         end
      endcase

      if (ram_rd_en) begin
         rd_written_in = written_ff[ram_rd_addr];
      end
   end

   // result capture
   always_comb begin
      rsp_valid_in        = fin;
      rsp_ok_in           = rsp_ok_ff;
      rsp_slot_id_in      = rsp_slot_id_ff;
      rsp_current_task_in = rsp_current_task_ff;
      rsp_went_idle_in    = rsp_went_idle_ff;
      rsp_busy_ticks_in   = rsp_busy_ticks_ff;
      rsp_idle_ticks_in   = rsp_idle_ticks_ff;
      rsp_total_ticks_in  = rsp_total_ticks_ff;
      rsp_stop_in         = rsp_stop_ff;
      if (fin) begin
         rsp_ok_in           = fin_ok;
         rsp_slot_id_in      = fin_sid;
         rsp_current_task_in = wrrts_pkg::SLOT_W'(running_in);
         rsp_went_idle_in    = fin_idle;
         rsp_busy_ticks_in   = fin_stats ? rd_entry.busy : '0;
         rsp_idle_ticks_in   = fin_stats ? idle_count_ff : '0;
         rsp_total_ticks_in  = fin_stats ? tick_total_ff : '0;
         rsp_stop_in         = fin_stats & rd_entry.stop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wmin_ff       <= wrrts_pkg::WEIGHT_MIN_RESET;
         wmax_ff       <= wrrts_pkg::WEIGHT_MAX_RESET;
         status_ff     <= '{default: wrrts_pkg::TS_UNUSED};
         written_ff    <= '0;
         running_ff    <= '0;
         idle_count_ff <= '0;
         tick_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wmin_ff       <= wmin_in;
         wmax_ff       <= wmax_in;
         status_ff     <= status_in;
         written_ff    <= written_in;
         running_ff    <= running_in;
         idle_count_ff <= idle_count_in;
         tick_total_ff <= tick_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff         <= item_cmd_in;
      item_slot_ff        <= item_slot_in;
      item_weight_ff      <= item_weight_in;
      probe_ff            <= probe_in;
      left_ff             <= left_in;
      rd_written_ff       <= rd_written_in;
      rsp_ok_ff           <= rsp_ok_in;
      rsp_slot_id_ff      <= rsp_slot_id_in;
      rsp_current_task_ff <= rsp_current_task_in;
      rsp_went_idle_ff    <= rsp_went_idle_in;
      rsp_busy_ticks_ff   <= rsp_busy_ticks_in;
      rsp_idle_ticks_ff   <= rsp_idle_ticks_in;
      rsp_total_ticks_ff  <= rsp_total_ticks_in;
      rsp_stop_ff         <= rsp_stop_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_slot_id        = rsp_slot_id_ff;
   assign rsp_current_task   = rsp_current_task_ff;
   assign rsp_went_idle      = rsp_went_idle_ff;
   assign rsp_busy_ticks     = rsp_busy_ticks_ff;
   assign rsp_idle_ticks     = rsp_idle_ticks_ff;
   assign rsp_total_ticks    = rsp_total_ticks_ff;
   assign rsp_stop_flag      = rsp_stop_ff;

endmodule

// ===== rtl/weighted_round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// weighted round-robin task scheduler
// task table with weights and budgets, tick scheduling and task commands
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// req       in         start high, busy low        req_cmd, req_slot, req_weight
// rsp       out        rsp_valid for one cycle     rsp_ok .. rsp_stop_flag
// csr       in         csr_valid and csr_ready     csr_index, csr_data
//
// block, wake and commands rejected at decode finish in the decode state; unregister,
// set weight, request stop, read stats and a budget-keeping tick add a task ram read
// before the result; register probes the slots from the lowest and a rescheduling
// tick scans them in round-robin order; the slot scans step one slot a cycle and every
// task word goes through the registered read port of the task ram
// a new transaction is taken in the cycle the previous result is strobed
// synchronous reset clears the status flags at once, no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle
//
module weighted_round_robin_task_scheduler #(
   parameter int NUM_TASKS = wrrts_pkg::NUM_TASKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request transaction
   input  logic                              start,
   output logic                              busy,
   input  logic [wrrts_pkg::CMD_W-1:0]       req_cmd,
   input  logic [wrrts_pkg::SLOT_W-1:0]      req_slot,
   input  logic [wrrts_pkg::WEIGHT_W-1:0]    req_weight,
   // result transaction
   output logic                              rsp_valid,
   output logic                              rsp_ok,
   output logic [wrrts_pkg::SLOT_W-1:0]      rsp_slot_id,
   output logic [wrrts_pkg::SLOT_W-1:0]      rsp_current_task,
   output logic                              rsp_went_idle,
   output logic [wrrts_pkg::COUNT_W-1:0]     rsp_busy_ticks,
   output logic [wrrts_pkg::COUNT_W-1:0]     rsp_idle_ticks,
   output logic [wrrts_pkg::COUNT_W-1:0]     rsp_total_ticks,
   output logic                              rsp_stop_flag,
   // register write transaction
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wrrts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wrrts_pkg::WEIGHT_W-1:0]    csr_data
);

   `include "weighted_round_robin_task_scheduler_assert.svh"

   wrrts_pkg::dp_status_type dp_status;
   wrrts_pkg::dp_op_type     dp_op;

   // register writes only with no transaction in flight or being taken
   assign csr_ready = !busy && !start;

   // controller: sequences each command through the datapath
   wrrts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .op     (dp_op)
   );

   // datapath: task table, task ram, counters and result registers
   wrrts_dp #(
      .NUM_TASKS (NUM_TASKS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .op                 (dp_op),
      .status             (dp_status),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_weight         (req_weight),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_slot_id        (rsp_slot_id),
      .rsp_current_task   (rsp_current_task),
      .rsp_went_idle      (rsp_went_idle),
      .rsp_busy_ticks     (rsp_busy_ticks),
      .rsp_idle_ticks     (rsp_idle_ticks),
      .rsp_total_ticks    (rsp_total_ticks),
      .rsp_stop_flag      (rsp_stop_flag)
   );

   // one strobe per transaction, never two in a row
   `WRRTS_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)

   // an accepted transaction always starts work
   `WRRTS_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)

   // a result only follows a cycle of work
   `WRRTS_ASSERT(a_rsp_after_work, clock, reset, rsp_valid |-> $past(busy))

   // an idle tick is a successful tick and assigns no slot
   `WRRTS_ASSERT_MSG(a_idle_tick, clock, reset,
      (rsp_valid && rsp_went_idle) |-> (rsp_ok && (rsp_slot_id == 3'd0)),
      "idle tick reported with bad ok or slot id")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// weighted round-robin task scheduler testbench
// drives task commands and ticks through the start/busy port, keeps a
// shadow task table that computes the expected result of every transaction,
// and compares each strobed result field by field in order of acceptance
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS        = wrrts_pkg::NUM_TASKS_DEFAULT;
   localparam int CMD_W        = wrrts_pkg::CMD_W;
   localparam int SLOT_W       = wrrts_pkg::SLOT_W;
   localparam int WEIGHT_W     = wrrts_pkg::WEIGHT_W;
   localparam int COUNT_W      = wrrts_pkg::COUNT_W;
   localparam int CSR_INDEX_W  = wrrts_pkg::CSR_INDEX_W;
   // longest result path is a rescheduling tick
   localparam int DRAIN_CYCLES = SLOTS + 8;
   // cycles with no accepted transaction, result or register write before the run is declared hung
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 150;

   // one result transaction as seen on the rsp_ ports
   typedef struct packed {
      logic                ok;
      logic [SLOT_W-1:0]   slot_id;
      logic [SLOT_W-1:0]   current_task;
      logic                went_idle;
      logic [COUNT_W-1:0]  busy_ticks;
      logic [COUNT_W-1:0]  idle_ticks;
      logic [COUNT_W-1:0]  total_ticks;
      logic                stop_flag;
   } sched_result_type;

   // block ports, all inputs known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [CMD_W-1:0]       req_cmd = '0;
   logic [SLOT_W-1:0]      req_slot = '0;
   logic [WEIGHT_W-1:0]    req_weight = '0;
   logic                   rsp_valid;
   logic                   rsp_ok;
   logic [SLOT_W-1:0]      rsp_slot_id;
   logic [SLOT_W-1:0]      rsp_current_task;
   logic                   rsp_went_idle;
   logic [COUNT_W-1:0]     rsp_busy_ticks;
   logic [COUNT_W-1:0]     rsp_idle_ticks;
   logic [COUNT_W-1:0]     rsp_total_ticks;
   logic                   rsp_stop_flag;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [WEIGHT_W-1:0]    csr_data = '0;

   // shadow task table and counters
   wrrts_pkg::task_state_type tbl_status [SLOTS];
   logic [WEIGHT_W-1:0]    tbl_weight [SLOTS];
   logic [WEIGHT_W-1:0]    tbl_budget [SLOTS];
   logic                   tbl_stop   [SLOTS];
   logic [COUNT_W-1:0]     tbl_busy   [SLOTS];
   logic [COUNT_W-1:0]     idle_total = '0;
   logic [COUNT_W-1:0]     tick_count = '0;
   logic [SLOT_W-1:0]      run_slot = '0;
   logic [WEIGHT_W-1:0]    lim_min = wrrts_pkg::WEIGHT_MIN_RESET;
   logic [WEIGHT_W-1:0]    lim_max = wrrts_pkg::WEIGHT_MAX_RESET;

   sched_result_type       pending_results [$];
   int                     err_count = 0;
   int                     stall_cycles = 0;
   int                     cmd_seen [8];
   int                     limit_sets = 0;
   bit                     gaps_on = 1'b1;

   weighted_round_robin_task_scheduler #(
      .NUM_TASKS(SLOTS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_weight         (req_weight),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_slot_id        (rsp_slot_id),
      .rsp_current_task   (rsp_current_task),
      .rsp_went_idle      (rsp_went_idle),
      .rsp_busy_ticks     (rsp_busy_ticks),
      .rsp_idle_ticks     (rsp_idle_ticks),
      .rsp_total_ticks    (rsp_total_ticks),
      .rsp_stop_flag      (rsp_stop_flag),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_status[i] = wrrts_pkg::TS_UNUSED;
         tbl_weight[i] = '0;
         tbl_budget[i] = '0;
         tbl_stop[i]   = 1'b0;
         tbl_busy[i]   = '0;
      end
      for (int i = 0; i < 8; i++) begin
         cmd_seen[i] = 0;
      end
   end

   // weight limits: lower bound is tested first, so an inverted pair
   // still gives a defined result
   function automatic logic [WEIGHT_W-1:0] clamp_weight(logic [WEIGHT_W-1:0] w);
      if (w < lim_min) begin
         return lim_min;
      end
      if (w > lim_max) begin
         return lim_max;
      end
      return w;
   endfunction

   // applies one command to the shadow table and returns the result it gives
   function automatic sched_result_type apply_command(wrrts_pkg::cmd_type c,
                                                      logic [SLOT_W-1:0] s,
                                                      logic [WEIGHT_W-1:0] w);
      sched_result_type    r;
      logic [SLOT_W-1:0]   probe;
      logic [WEIGHT_W-1:0] nw;
      bit                  found;
      bit                  used;
      r     = '0;
      found = 1'b0;
      used  = (tbl_status[s] != wrrts_pkg::TS_UNUSED);
      case (c)
         wrrts_pkg::CMD_TICK: begin
            r.ok = 1'b1;
            tick_count++;
            // running task keeps the slot while budget is above one
            if (tbl_status[run_slot] == wrrts_pkg::TS_READY) begin
               if (tbl_budget[run_slot] > 1) begin
                  tbl_budget[run_slot]--;
                  tbl_busy[run_slot]++;
                  found = 1'b1;
               end else begin
                  tbl_budget[run_slot] = tbl_weight[run_slot];
               end
            end
            // round-robin scan starting after the running slot, ending on it
            probe = run_slot;
            for (int i = 0; i < SLOTS && !found; i++) begin
               probe = (probe == SLOTS - 1) ? '0 : probe + 1'b1;
               if (tbl_status[probe] == wrrts_pkg::TS_READY) begin
                  if (tbl_budget[probe] == 0) begin
                     tbl_budget[probe] = tbl_weight[probe];
                  end
                  run_slot = probe;
                  tbl_busy[probe]++;
                  found = 1'b1;
               end
            end
            if (!found) begin
               idle_total++;
               r.went_idle = 1'b1;
            end
         end
         wrrts_pkg::CMD_REGISTER: begin
            // lowest unused slot; a full table leaves ok and slot_id at zero
            for (int i = 0; i < SLOTS && !found; i++) begin
               if (tbl_status[i] == wrrts_pkg::TS_UNUSED) begin
                  tbl_status[i] = wrrts_pkg::TS_READY;
                  tbl_weight[i] = clamp_weight(w);
                  tbl_budget[i] = tbl_weight[i];
                  tbl_stop[i]   = 1'b0;
                  tbl_busy[i]   = '0;
                  r.ok          = 1'b1;
                  r.slot_id     = SLOT_W'(i);
                  found         = 1'b1;
               end
            end
         end
         wrrts_pkg::CMD_UNREGISTER: begin
            // busy count survives until the slot is taken again
            if (used) begin
               tbl_status[s] = wrrts_pkg::TS_UNUSED;
               tbl_weight[s] = '0;
               tbl_budget[s] = '0;
               tbl_stop[s]   = 1'b0;
               r.ok          = 1'b1;
            end
         end
         wrrts_pkg::CMD_SET_WEIGHT: begin
            if (used) begin
               nw = clamp_weight(w);
               tbl_weight[s] = nw;
               if (tbl_budget[s] == 0 || tbl_budget[s] > nw) begin
                  tbl_budget[s] = nw;
               end
               r.ok = 1'b1;
            end
         end
         wrrts_pkg::CMD_STOP: begin
            // a stop request wakes a waiting task
            if (used) begin
               tbl_stop[s] = 1'b1;
               if (tbl_status[s] == wrrts_pkg::TS_WAITING) begin
                  tbl_status[s] = wrrts_pkg::TS_READY;
               end
               r.ok = 1'b1;
            end
         end
         wrrts_pkg::CMD_BLOCK: begin
            if (used) begin
               tbl_status[s] = wrrts_pkg::TS_WAITING;
               r.ok = 1'b1;
            end
         end
         wrrts_pkg::CMD_WAKE: begin
            if (used) begin
               if (tbl_status[s] == wrrts_pkg::TS_WAITING) begin
                  tbl_status[s] = wrrts_pkg::TS_READY;
               end
               r.ok = 1'b1;
            end
         end
         default: begin
            // stats read ignores the slot status
            r.ok          = 1'b1;
            r.busy_ticks  = tbl_busy[s];
            r.idle_ticks  = idle_total;
            r.total_ticks = tick_count;
            r.stop_flag   = tbl_stop[s];
         end
      endcase
      r.current_task = run_slot;
      return r;
   endfunction

   task automatic check_field(string name, logic [COUNT_W-1:0] want,
                              logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         err_count++;
      end
   endtask

   // scoreboard: checks strobed results, then records newly accepted
   // transactions and register writes; all sampled at the rising edge
   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type want;
      bit               active;
      active = 1'b0;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            active              = 1'b1;
            got.ok              = rsp_ok;
            got.slot_id         = rsp_slot_id;
            got.current_task    = rsp_current_task;
            got.went_idle       = rsp_went_idle;
            got.busy_ticks      = rsp_busy_ticks;
            got.idle_ticks      = rsp_idle_ticks;
            got.total_ticks     = rsp_total_ticks;
            got.stop_flag       = rsp_stop_flag;
            if (pending_results.size() == 0) begin
               $error("result transaction with no command outstanding");
               err_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("ok", COUNT_W'(want.ok), COUNT_W'(got.ok));
               check_field("slot_id", COUNT_W'(want.slot_id), COUNT_W'(got.slot_id));
               check_field("current_task", COUNT_W'(want.current_task),
                           COUNT_W'(got.current_task));
               check_field("went_idle", COUNT_W'(want.went_idle), COUNT_W'(got.went_idle));
               check_field("busy_ticks", want.busy_ticks, got.busy_ticks);
               check_field("idle_ticks", want.idle_ticks, got.idle_ticks);
               check_field("total_ticks", want.total_ticks, got.total_ticks);
               check_field("stop_flag", COUNT_W'(want.stop_flag), COUNT_W'(got.stop_flag));
            end
         end
         if (start && busy === 1'b0) begin
            active = 1'b1;
            pending_results.push_back(apply_command(wrrts_pkg::cmd_type'(req_cmd),
                                                    req_slot, req_weight));
            cmd_seen[req_cmd]++;
         end
         if (csr_valid && csr_ready === 1'b1) begin
            active = 1'b1;
            if (csr_index == wrrts_pkg::CSR_WEIGHT_MIN) begin
               lim_min = csr_data;
            end else if (csr_index == wrrts_pkg::CSR_WEIGHT_MAX) begin
               lim_max = csr_data;
            end
         end
         stall_cycles = active ? 0 : stall_cycles + 1;
      end
   end

   // watchdog: too long without any accepted transaction, result or register write
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one command transaction; start stays high when the next one follows
   // directly, and drops only during a random gap or in wait_for_results
   task automatic send_item(wrrts_pkg::cmd_type c, logic [SLOT_W-1:0] s,
                            logic [WEIGHT_W-1:0] w);
      while (gaps_on && $urandom_range(99) < 23) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_cmd    <= c;
      req_slot   <= s;
      req_weight <= w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // sender holds off until every outstanding result has arrived
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; caller lowers it
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [WEIGHT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
   endtask

   // limits change only with the block idle
   task automatic set_limits(logic [WEIGHT_W-1:0] lo, logic [WEIGHT_W-1:0] hi);
      wait_for_results();
      write_reg(wrrts_pkg::CSR_WEIGHT_MIN, lo);
      write_reg(wrrts_pkg::CSR_WEIGHT_MAX, hi);
      csr_valid <= 1'b0;
      limit_sets++;
   endtask

   // empty table: idle tick, stats of a never-used slot, command on unused slot
   task automatic test_reset_state();
      send_item(wrrts_pkg::CMD_TICK, 3'd0, 8'd0);
      send_item(wrrts_pkg::CMD_STATS, 3'd6, 8'd0);
      send_item(wrrts_pkg::CMD_BLOCK, 3'd4, 8'd0);
   endtask

   // fill every slot with clamped weights, then one register on a full table
   task automatic test_table_fill();
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'h00);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'hFF);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd7, 8'h07);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'h80);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'h01);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'h10);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'h0F);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'hAA);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'h05);
   endtask

   // block/wake, stop waking a waiting task, reweight, slot reuse, stats, tick
   task automatic test_task_commands();
      send_item(wrrts_pkg::CMD_BLOCK, 3'd2, 8'd0);
      send_item(wrrts_pkg::CMD_WAKE, 3'd2, 8'd0);
      send_item(wrrts_pkg::CMD_BLOCK, 3'd3, 8'd0);
      send_item(wrrts_pkg::CMD_STOP, 3'd3, 8'd0);
      send_item(wrrts_pkg::CMD_SET_WEIGHT, 3'd1, 8'h00);
      send_item(wrrts_pkg::CMD_UNREGISTER, 3'd5, 8'd0);
      send_item(wrrts_pkg::CMD_REGISTER, 3'd0, 8'hFF);
      send_item(wrrts_pkg::CMD_STATS, 3'd3, 8'd0);
      send_item(wrrts_pkg::CMD_TICK, 3'd0, 8'd0);
   endtask

   // lower limit above upper limit
   task automatic test_inverted_clamp();
      set_limits(8'd200, 8'd10);
      send_item(wrrts_pkg::CMD_SET_WEIGHT, 3'd0, 8'd5);
      send_item(wrrts_pkg::CMD_SET_WEIGHT, 3'd0, 8'd250);
      send_item(wrrts_pkg::CMD_STATS, 3'd5, 8'd0);
   endtask

   // random mix, ticks most often, over several limit settings
   task automatic test_random_traffic();
      int                  pick;
      wrrts_pkg::cmd_type  c;
      logic [WEIGHT_W-1:0] w;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_limits(8'd1, 8'd16);
            1: set_limits(8'd1, 8'd255);
            2: set_limits(8'd2, 8'd3);
            3: set_limits(8'd200, 8'd10);
            4: set_limits(8'd255, 8'd255);
            default: set_limits(8'd1, 8'd1);
         endcase
         // one whole phase runs back to back with no sender gaps
         gaps_on = (phase != 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 1 && k == PHASE_ITEMS / 2) begin
               wait_for_results();
            end
            pick = $urandom_range(99);
            if (pick < 40) c = wrrts_pkg::CMD_TICK;
            else if (pick < 50) c = wrrts_pkg::CMD_REGISTER;
            else if (pick < 58) c = wrrts_pkg::CMD_UNREGISTER;
            else if (pick < 67) c = wrrts_pkg::CMD_SET_WEIGHT;
            else if (pick < 74) c = wrrts_pkg::CMD_STOP;
            else if (pick < 84) c = wrrts_pkg::CMD_BLOCK;
            else if (pick < 93) c = wrrts_pkg::CMD_WAKE;
            else c = wrrts_pkg::CMD_STATS;
            case ($urandom_range(3))
               0: w = WEIGHT_W'($urandom_range(255));
               1: w = WEIGHT_W'($urandom_range(1, 6));
               2: w = $urandom_range(1) ? 8'hFF : 8'h00;
               default: w = WEIGHT_W'($urandom_range(20));
            endcase
            send_item(c, SLOT_W'($urandom_range(SLOTS - 1)), w);
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      // synchronous reset held from time zero, then released
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_table_fill();
      test_task_commands();
      test_inverted_clamp();
      test_random_traffic();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         err_count++;
      end
      $display("covered %0d commands: %0d ticks (%0d idle), %0d registers, %0d stats reads",
               cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3] + cmd_seen[4]
               + cmd_seen[5] + cmd_seen[6] + cmd_seen[7], cmd_seen[wrrts_pkg::CMD_TICK],
               idle_total, cmd_seen[wrrts_pkg::CMD_REGISTER],
               cmd_seen[wrrts_pkg::CMD_STATS]);
      $display("weight limit pairs applied: %0d, including inverted and extreme pairs",
               limit_sets);
      if (err_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
